/* src/mpcs_pkg.sv */
package mpcs_pkg;

    localparam int TIME_BITS = 16;
    localparam int SLOTS_DEF = 8;

    localparam logic [2:0] POOL_EMPTY    = 3'd0;
    localparam logic [2:0] POOL_NEW      = 3'd1;
    localparam logic [2:0] POOL_READY    = 3'd2;
    localparam logic [2:0] POOL_WAITING  = 3'd3;
    localparam logic [2:0] POOL_FINISHED = 3'd4;

    localparam logic [2:0] POL_FCFS  = 3'd0;
    localparam logic [2:0] POL_SJF   = 3'd1;
    localparam logic [2:0] POL_PSJF  = 3'd2;
    localparam logic [2:0] POL_PRIO  = 3'd3;
    localparam logic [2:0] POL_PPRIO = 3'd4;
    localparam logic [2:0] POL_RR    = 3'd5;

    localparam logic CFG_POLICY  = 1'b0;
    localparam logic CFG_QUANTUM = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [TIME_BITS-1:0] time_t;

    typedef struct packed {
        logic [12:0] ident;
        time_t       key;
        logic [7:0]  rem;
        logic [7:0]  rank;
        logic        iop;
        logic [7:0]  iocd;
        logic [7:0]  iol;
        time_t       wcnt;
        time_t       tcnt;
    } slot_entry_t;

    typedef struct packed {
        logic       we;
        logic [2:0] pool;
    } slot_wr_t;

    function automatic time_t sat_inc(input time_t v);
        time_t r;
        if (v == {TIME_BITS{1'b1}})
            r = v;
        else
            r = v + time_t'(1);
        return r;
    endfunction

endpackage

/* src/mpcs_slot_file.sv */
module mpcs_slot_file #(
    parameter int SLOTS = mpcs_pkg::SLOTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    output mpcs_pkg::slot_entry_t         rd_entry,
    output logic [2:0]                    rd_pool,
    input  mpcs_pkg::slot_wr_t            wr,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  mpcs_pkg::slot_entry_t         wentry,
    output logic                          all_done
);

    mpcs_pkg::slot_entry_t entry_reg [SLOTS];
    logic [2:0]            pool_reg  [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            entry_reg[waddr] <= wentry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                pool_reg[i] <= mpcs_pkg::POOL_EMPTY;
            end
        end
        else if (wr.we)
        begin
            pool_reg[waddr] <= wr.pool;
        end
    end

    assign rd_entry = entry_reg[raddr];
    assign rd_pool  = pool_reg[raddr];

    always_comb
    begin
        all_done = 1'b1;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pool_reg[i] == mpcs_pkg::POOL_NEW || pool_reg[i] == mpcs_pkg::POOL_READY
                || pool_reg[i] == mpcs_pkg::POOL_WAITING)
            begin
                all_done = 1'b0;
            end
        end
    end

endmodule

/* src/multi_policy_cpu_scheduler_sim.sv */
// channel | dir | handshake          | payload
// cfg     | in  | cfg_we             | cfg_index, cfg_data
// in      | in  | in_valid/in_stall  | op, slot, pid, arrive_at, run_len, io_*, priority_req
// out     | out | out_valid/out_stall| idle, running_pid, done_*, all_finished
//
// A tick: one per-slot unit walks the slot file once to admit, once to pick the least key
// (only when the choice is redone), once to count, then runs one slot; when nothing is
// ready it stops after the admit pass. A load writes its slot directly.
// Async active-low reset empties all slots, sets policy 0 and quantum 3.
// in_stall is high while a word is in work or its result cannot be placed in the
// output register; the next word may enter while a result waits on out_stall.
module multi_policy_cpu_scheduler_sim #(
    parameter int SLOTS = mpcs_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [2:0]  slot,
    input  logic [12:0] pid,
    input  logic [15:0] arrive_at,
    input  logic [7:0]  run_len,
    input  logic        io_on,
    input  logic [7:0]  io_after,
    input  logic [7:0]  io_len,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        idle,
    output logic [12:0] running_pid,
    output logic        done_valid,
    output logic [12:0] done_pid,
    output logic [15:0] done_wait,
    output logic [15:0] done_turnaround,
    output logic        all_finished
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
    localparam int TB = mpcs_pkg::TIME_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ADMIT = 3'd1;
    localparam logic [2:0] S_SEL   = 3'd2;
    localparam logic [2:0] S_ACCT  = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [2:0]          policy_reg;
    logic [7:0]          quantum_reg;
    mpcs_pkg::time_t     tick_reg, tick_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [7:0]          slice_reg, slice_next;
    logic                arrived_reg, arrived_next;
    logic                any_ready_reg, any_ready_next;
    logic                cur_ready_reg, cur_ready_next;
    logic                found_reg, found_next;
    mpcs_pkg::time_t     best_reg, best_next;
    logic [IDX_W-1:0]    bi_reg, bi_next;

    logic                r_idle_reg, r_idle_next;
    logic [12:0]         r_pid_reg, r_pid_next;
    logic                r_done_reg, r_done_next;
    logic [12:0]         r_dpid_reg, r_dpid_next;
    logic [15:0]         r_dw_reg, r_dw_next;
    logic [15:0]         r_dt_reg, r_dt_next;

    logic                out_valid_reg;
    logic                idle_reg, done_valid_reg, all_finished_reg;
    logic [12:0]         running_pid_reg, done_pid_reg;
    logic [15:0]         done_wait_reg, done_turnaround_reg;

    logic [IDX_W-1:0]      raddr, waddr;
    mpcs_pkg::slot_entry_t rd, we_entry;
    logic [2:0]            rd_pool;
    mpcs_pkg::slot_wr_t    wr;
    logic                  all_done;

    logic                  accept, out_free, last;
    mpcs_pkg::time_t       skey;
    logic [2:0]            np;
    logic [7:0]            slice_inc;
    logic                  expired;
    logic [TB:0]           back;

    mpcs_slot_file #(.SLOTS(SLOTS)) u_slots (
        .clk      (clk),
        .rst_n    (rst_n),
        .raddr    (raddr),
        .rd_entry (rd),
        .rd_pool  (rd_pool),
        .wr       (wr),
        .waddr    (waddr),
        .wentry   (we_entry),
        .all_done (all_done)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign last     = (idx_reg == IDX_LAST);
    assign raddr    = (state_reg == S_RUN) ? cur_reg : idx_reg;

    always_comb
    begin
        if (policy_reg == mpcs_pkg::POL_SJF || policy_reg == mpcs_pkg::POL_PSJF)
            skey = mpcs_pkg::time_t'(rd.rem);
        else if (policy_reg == mpcs_pkg::POL_PRIO || policy_reg == mpcs_pkg::POL_PPRIO)
            skey = mpcs_pkg::time_t'(rd.rank);
        else
            skey = rd.key;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        tick_next      = tick_reg;
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        slice_next     = slice_reg;
        arrived_next   = arrived_reg;
        any_ready_next = any_ready_reg;
        cur_ready_next = cur_ready_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        bi_next        = bi_reg;
        r_idle_next    = r_idle_reg;
        r_pid_next     = r_pid_reg;
        r_done_next    = r_done_reg;
        r_dpid_next    = r_dpid_reg;
        r_dw_next      = r_dw_reg;
        r_dt_next      = r_dt_reg;
        wr.we          = 1'b0;
        wr.pool        = rd_pool;
        waddr          = raddr;
        we_entry       = rd;
        np             = rd_pool;
        slice_inc      = slice_reg + 8'd1;
        expired        = 1'b0;
        back           = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    r_idle_next = 1'b0;
                    r_pid_next  = '0;
                    r_done_next = 1'b0;
                    r_dpid_next = '0;
                    r_dw_next   = '0;
                    r_dt_next   = '0;
                    idx_next    = '0;
                    if (op == mpcs_pkg::OP_LOAD)
                    begin
                        wr.we          = (32'(slot) < SLOTS);
                        wr.pool        = mpcs_pkg::POOL_NEW;
                        waddr          = IDX_W'(slot);
                        we_entry.ident = pid;
                        we_entry.key   = mpcs_pkg::time_t'(arrive_at);
                        we_entry.rem   = run_len;
                        we_entry.iop   = io_on;
                        we_entry.iocd  = io_after;
                        we_entry.iol   = io_len;
                        we_entry.rank  = priority_req;
                        we_entry.wcnt  = '0;
                        we_entry.tcnt  = '0;
                        tick_next      = '0;
                        cur_valid_next = 1'b0;
                        slice_next     = '0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        arrived_next   = 1'b0;
                        any_ready_next = 1'b0;
                        cur_ready_next = 1'b0;
                        state_next     = S_ADMIT;
                    end
                end
            end

            S_ADMIT:
            begin
                wr.we = 1'b1;
                if (rd_pool == mpcs_pkg::POOL_NEW && rd.key == tick_reg)
                begin
                    np           = mpcs_pkg::POOL_READY;
                    arrived_next = 1'b1;
                end
                else if (rd_pool == mpcs_pkg::POOL_WAITING && rd.iol == 8'd0)
                begin
                    np           = mpcs_pkg::POOL_READY;
                    arrived_next = 1'b1;
                end
                wr.pool = np;
                // slots still blocked on io age here; same as counting after the scan
                if (np == mpcs_pkg::POOL_WAITING)
                begin
                    we_entry.tcnt = mpcs_pkg::sat_inc(rd.tcnt);
                    we_entry.wcnt = mpcs_pkg::sat_inc(rd.wcnt);
                    if (rd.iol != 8'd0)
                        we_entry.iol = rd.iol - 8'd1;
                end
                if (np == mpcs_pkg::POOL_READY)
                    any_ready_next = 1'b1;
                if (idx_reg == cur_reg)
                    cur_ready_next = (np == mpcs_pkg::POOL_READY);
                idx_next = idx_reg + IDX_W'(1);
                if (last)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (!any_ready_next)
                    begin
                        cur_valid_next = 1'b0;
                        slice_next     = '0;
                        tick_next      = mpcs_pkg::sat_inc(tick_reg);
                        r_idle_next    = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (!cur_valid_reg || !(32'(cur_reg) < SLOTS) || !cur_ready_next
                             || ((policy_reg == mpcs_pkg::POL_PSJF
                                  || policy_reg == mpcs_pkg::POL_PPRIO) && arrived_next))
                        state_next = S_SEL;
                    else
                        state_next = S_ACCT;
                end
            end

            S_SEL:
            begin
                if (rd_pool == mpcs_pkg::POOL_READY && (!found_reg || skey < best_reg))
                begin
                    found_next = 1'b1;
                    best_next  = skey;
                    bi_next    = idx_reg;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (last)
                begin
                    idx_next       = '0;
                    cur_next       = bi_next;
                    cur_valid_next = 1'b1;
                    state_next     = S_ACCT;
                end
            end

            S_ACCT:
            begin
                wr.we = 1'b1;
                if (rd_pool == mpcs_pkg::POOL_READY)
                begin
                    we_entry.tcnt = mpcs_pkg::sat_inc(rd.tcnt);
                    if (idx_reg != cur_reg)
                        we_entry.wcnt = mpcs_pkg::sat_inc(rd.wcnt);
                end
                idx_next = idx_reg + IDX_W'(1);
                if (last)
                begin
                    idx_next   = '0;
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                wr.we      = 1'b1;
                r_pid_next = rd.ident;
                if (rd.rem != 8'd0)
                    we_entry.rem = rd.rem - 8'd1;
                if (rd.iop && rd.iocd != 8'd0)
                    we_entry.iocd = rd.iocd - 8'd1;
                if (policy_reg == mpcs_pkg::POL_RR)
                begin
                    slice_next = slice_inc;
                    if (slice_inc == quantum_reg)
                    begin
                        expired      = 1'b1;
                        we_entry.key = tick_reg;
                    end
                end
                if (we_entry.rem == 8'd0)
                begin
                    wr.pool        = mpcs_pkg::POOL_FINISHED;
                    cur_valid_next = 1'b0;
                    slice_next     = '0;
                    r_done_next    = 1'b1;
                    r_dpid_next    = rd.ident;
                    r_dw_next      = rd.wcnt;
                    r_dt_next      = rd.tcnt;
                end
                else if (rd.iop && we_entry.iocd == 8'd0)
                begin
                    back = {1'b0, tick_reg} + (TB + 1)'(rd.iol);
                    we_entry.key   = back[TB] ? {TB{1'b1}} : back[TB-1:0];
                    we_entry.iop   = 1'b0;
                    wr.pool        = mpcs_pkg::POOL_WAITING;
                    cur_valid_next = 1'b0;
                    slice_next     = '0;
                end
                else if (expired)
                begin
                    cur_valid_next = 1'b0;
                    slice_next     = '0;
                end
                tick_next  = mpcs_pkg::sat_inc(tick_reg);
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            policy_reg    <= mpcs_pkg::POL_FCFS;
            quantum_reg   <= 8'd3;
            tick_reg      <= '0;
            cur_reg       <= '0;
            cur_valid_reg <= 1'b0;
            slice_reg     <= '0;
            arrived_reg   <= 1'b0;
            any_ready_reg <= 1'b0;
            cur_ready_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            tick_reg      <= tick_next;
            cur_reg       <= cur_next;
            cur_valid_reg <= cur_valid_next;
            slice_reg     <= slice_next;
            arrived_reg   <= arrived_next;
            any_ready_reg <= any_ready_next;
            cur_ready_reg <= cur_ready_next;
            found_reg     <= found_next;
            if (cfg_we)
            begin
                if (cfg_index == mpcs_pkg::CFG_POLICY)
                    policy_reg <= cfg_data[2:0];
                else
                    quantum_reg <= cfg_data;
            end
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg    <= best_next;
        bi_reg      <= bi_next;
        r_idle_reg  <= r_idle_next;
        r_pid_reg   <= r_pid_next;
        r_done_reg  <= r_done_next;
        r_dpid_reg  <= r_dpid_next;
        r_dw_reg    <= r_dw_next;
        r_dt_reg    <= r_dt_next;
        if (state_reg == S_OUT && out_free)
        begin
            idle_reg            <= r_idle_reg;
            running_pid_reg     <= r_pid_reg;
            done_valid_reg      <= r_done_reg;
            done_pid_reg        <= r_dpid_reg;
            done_wait_reg       <= r_dw_reg;
            done_turnaround_reg <= r_dt_reg;
            all_finished_reg    <= all_done;
        end
    end

    assign out_valid       = out_valid_reg;
    assign idle            = idle_reg;
    assign running_pid     = running_pid_reg;
    assign done_valid      = done_valid_reg;
    assign done_pid        = done_pid_reg;
    assign done_wait       = done_wait_reg;
    assign done_turnaround = done_turnaround_reg;
    assign all_finished    = all_finished_reg;

    a_run_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RUN |-> cur_valid_reg && (32'(cur_reg) < SLOTS))
        else $error("run step without a chosen slot");

    a_out_lands: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && out_free |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not placed in output register");

    a_sel_after_admit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEL |-> $past(state_reg) == S_ADMIT || $past(state_reg) == S_SEL)
        else $error("selection pass entered out of order");

endmodule

/* tb/multi_policy_cpu_scheduler_sim_tb.sv */
`timescale 1ns / 1ps

module multi_policy_cpu_scheduler_sim_tb;

    typedef struct {
        logic        idle;
        logic [12:0] running_pid;
        logic        done_valid;
        logic [12:0] done_pid;
        logic [15:0] done_wait;
        logic [15:0] done_turnaround;
        logic        all_finished;
    } sched_res_t;

    typedef struct {
        logic        op;
        logic [2:0]  slot;
        logic [12:0] pid;
        logic [15:0] arrive_at;
        logic [7:0]  run_len;
        logic        io_on;
        logic [7:0]  io_after;
        logic [7:0]  io_len;
        logic [7:0]  priority_req;
    } sched_word_t;

    class sched_scoreboard;
        logic [2:0]  policy;
        logic [7:0]  quantum;
        logic [2:0]  pool [8];
        logic [12:0] ident [8];
        logic [15:0] okey [8];
        logic [7:0]  remain [8];
        logic [7:0]  rank [8];
        logic        iop [8];
        logic [7:0]  iocd [8];
        logic [7:0]  iol [8];
        logic [15:0] wcnt [8];
        logic [15:0] tcnt [8];
        logic [15:0] ticks;
        logic [2:0]  cur;
        logic        cur_ok;
        logic [7:0]  slice;
        sched_res_t  pending [$];
        int          errors;
        int          results;
        int          completions;

        function void clear();
            policy = mpcs_pkg::POL_FCFS;
            quantum = 8'd3;
            for (int i = 0; i < 8; i++)
            begin
                pool[i] = mpcs_pkg::POOL_EMPTY;
                ident[i] = '0; okey[i] = '0; remain[i] = '0; rank[i] = '0;
                iop[i] = 1'b0; iocd[i] = '0; iol[i] = '0; wcnt[i] = '0; tcnt[i] = '0;
            end
            ticks = '0; cur = '0; cur_ok = 1'b0; slice = '0;
        endfunction

        function logic [15:0] sat(logic [15:0] v);
            return (v == 16'hffff) ? v : v + 16'd1;
        endfunction

        function logic all_done();
            for (int i = 0; i < 8; i++)
                if (pool[i] == mpcs_pkg::POOL_NEW || pool[i] == mpcs_pkg::POOL_READY
                    || pool[i] == mpcs_pkg::POOL_WAITING)
                    return 1'b0;
            return 1'b1;
        endfunction

        function logic [15:0] order_of(int i);
            if (policy == mpcs_pkg::POL_SJF || policy == mpcs_pkg::POL_PSJF)
                return {8'd0, remain[i]};
            if (policy == mpcs_pkg::POL_PRIO || policy == mpcs_pkg::POL_PPRIO)
                return {8'd0, rank[i]};
            return okey[i];
        endfunction

        function void age_blocked();
            for (int i = 0; i < 8; i++)
                if (pool[i] == mpcs_pkg::POOL_WAITING)
                begin
                    tcnt[i] = sat(tcnt[i]);
                    wcnt[i] = sat(wcnt[i]);
                    if (iol[i] != 0) iol[i]--;
                end
        endfunction

        function void note_word(sched_word_t w);
            sched_res_t r;
            logic arrived;
            logic any_ready;
            logic found;
            logic expired;
            logic [15:0] best_key;
            logic [16:0] back;
            int c;
            r = '{default: '0};
            arrived = 1'b0; any_ready = 1'b0; expired = 1'b0;
            if (w.op == mpcs_pkg::OP_LOAD)
            begin
                c = int'(w.slot);
                pool[c] = mpcs_pkg::POOL_NEW; ident[c] = w.pid; okey[c] = w.arrive_at;
                remain[c] = w.run_len; iop[c] = w.io_on; iocd[c] = w.io_after;
                iol[c] = w.io_len; rank[c] = w.priority_req; wcnt[c] = '0; tcnt[c] = '0;
                ticks = '0; cur_ok = 1'b0; slice = '0;
                r.all_finished = all_done();
                pending.push_back(r);
                return;
            end
            for (int i = 0; i < 8; i++)
            begin
                if (pool[i] == mpcs_pkg::POOL_NEW && okey[i] == ticks)
                begin
                    pool[i] = mpcs_pkg::POOL_READY; arrived = 1'b1;
                end
                else if (pool[i] == mpcs_pkg::POOL_WAITING && iol[i] == 0)
                begin
                    pool[i] = mpcs_pkg::POOL_READY; arrived = 1'b1;
                end
                if (pool[i] == mpcs_pkg::POOL_READY) any_ready = 1'b1;
            end
            if (!any_ready)
            begin
                age_blocked();
                cur_ok = 1'b0; slice = '0; ticks = sat(ticks);
                r.idle = 1'b1;
                r.all_finished = all_done();
                pending.push_back(r);
                return;
            end
            if (!cur_ok || pool[cur] != mpcs_pkg::POOL_READY
                || ((policy == mpcs_pkg::POL_PSJF || policy == mpcs_pkg::POL_PPRIO)
                    && arrived))
            begin
                found = 1'b0; best_key = '0; c = 0;
                for (int i = 0; i < 8; i++)
                    if (pool[i] == mpcs_pkg::POOL_READY && (!found || order_of(i) < best_key))
                    begin
                        found = 1'b1; best_key = order_of(i); c = i;
                    end
                cur = 3'(c); cur_ok = 1'b1;
            end
            c = int'(cur);
            for (int i = 0; i < 8; i++)
                if (pool[i] == mpcs_pkg::POOL_READY)
                begin
                    tcnt[i] = sat(tcnt[i]);
                    if (i != c) wcnt[i] = sat(wcnt[i]);
                end
            age_blocked();
            r.running_pid = ident[c];
            if (remain[c] != 0) remain[c]--;
            if (iop[c] && iocd[c] != 0) iocd[c]--;
            if (policy == mpcs_pkg::POL_RR)
            begin
                slice = slice + 8'd1;
                if (slice == quantum)
                begin
                    expired = 1'b1; okey[c] = ticks;
                end
            end
            if (remain[c] == 0)
            begin
                pool[c] = mpcs_pkg::POOL_FINISHED; cur_ok = 1'b0; slice = '0;
                r.done_valid = 1'b1; r.done_pid = ident[c];
                r.done_wait = wcnt[c]; r.done_turnaround = tcnt[c];
            end
            else if (iop[c] && iocd[c] == 0)
            begin
                back = {1'b0, ticks} + 17'(iol[c]);
                okey[c] = back[16] ? 16'hffff : back[15:0];
                iop[c] = 1'b0; pool[c] = mpcs_pkg::POOL_WAITING; cur_ok = 1'b0; slice = '0;
            end
            else if (expired)
            begin
                cur_ok = 1'b0; slice = '0;
            end
            ticks = sat(ticks);
            r.all_finished = all_done();
            pending.push_back(r);
        endfunction

        function void check_result(sched_res_t a);
            sched_res_t e;
            results++;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result word", $time);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.done_valid) completions++;
            if (a.idle !== e.idle)
                begin $display("%0t: idle exp %0d got %0d", $time, e.idle, a.idle); errors++; end
            if (a.running_pid !== e.running_pid)
                begin $display("%0t: running_pid exp %0d got %0d", $time, e.running_pid,
                    a.running_pid); errors++; end
            if (a.done_valid !== e.done_valid)
                begin $display("%0t: done_valid exp %0d got %0d", $time, e.done_valid,
                    a.done_valid); errors++; end
            if (a.done_pid !== e.done_pid)
                begin $display("%0t: done_pid exp %0d got %0d", $time, e.done_pid,
                    a.done_pid); errors++; end
            if (a.done_wait !== e.done_wait)
                begin $display("%0t: done_wait exp %0d got %0d", $time, e.done_wait,
                    a.done_wait); errors++; end
            if (a.done_turnaround !== e.done_turnaround)
                begin $display("%0t: done_turnaround exp %0d got %0d", $time,
                    e.done_turnaround, a.done_turnaround); errors++; end
            if (a.all_finished !== e.all_finished)
                begin $display("%0t: all_finished exp %0d got %0d", $time, e.all_finished,
                    a.all_finished); errors++; end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [2:0]  slot;
    logic [12:0] pid;
    logic [15:0] arrive_at;
    logic [7:0]  run_len;
    logic        io_on;
    logic [7:0]  io_after;
    logic [7:0]  io_len;
    logic [7:0]  priority_req;
    logic        out_valid;
    logic        out_stall;
    logic        idle;
    logic [12:0] running_pid;
    logic        done_valid;
    logic [12:0] done_pid;
    logic [15:0] done_wait;
    logic [15:0] done_turnaround;
    logic        all_finished;

    sched_scoreboard sb;
    int sender_idle_pct;
    int recv_stall_pct;
    int cycles;
    int words_sent;

    multi_policy_cpu_scheduler_sim u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 2000000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // output side: sample on rising edge, redraw stall at falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_result('{idle, running_pid, done_valid, done_pid, done_wait,
                    done_turnaround, all_finished});
            @(negedge clk);
            out_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic send_word(sched_word_t w);
        while ($urandom_range(99) < sender_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        op = w.op; slot = w.slot; pid = w.pid; arrive_at = w.arrive_at;
        run_len = w.run_len; io_on = w.io_on; io_after = w.io_after;
        io_len = w.io_len; priority_req = w.priority_req;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_word(w);
        words_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(posedge clk);
        if (idx == mpcs_pkg::CFG_POLICY) sb.policy = val[2:0];
        else sb.quantum = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic sched_word_t rand_load(int slot_hi);
        sched_word_t w;
        w.op = mpcs_pkg::OP_LOAD;
        w.slot = 3'($urandom_range(slot_hi));
        w.pid = 13'($urandom_range(8191, 1));
        w.arrive_at = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(12));
        w.run_len = ($urandom_range(19) == 0) ? 8'($urandom) : 8'($urandom_range(8));
        w.io_on = 1'($urandom);
        w.io_after = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(5));
        w.io_len = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
        w.priority_req = 8'($urandom);
        return w;
    endfunction

    function automatic sched_word_t tick_word();
        sched_word_t w;
        w = rand_load(7);
        w.op = mpcs_pkg::OP_TICK;
        return w;
    endfunction

    task automatic run_program(int nslots, int nticks);
        for (int i = 0; i < nslots; i++)
            send_word(rand_load(7));
        for (int i = 0; i < nticks; i++)
            send_word(tick_word());
    endtask

    initial
    begin
        sched_word_t w;
        sb = new();
        sb.clear();
        sb.errors = 0; sb.results = 0; sb.completions = 0;
        words_sent = 0;
        sender_idle_pct = 0; recv_stall_pct = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = mpcs_pkg::CFG_POLICY; cfg_data = '0;
        in_valid = 1'b0; op = mpcs_pkg::OP_TICK; slot = '0; pid = '0; arrive_at = '0;
        run_len = '0; io_on = 1'b0; io_after = '0; io_len = '0; priority_req = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty ticks, field extremes, zero burst, zero io delay and length
        send_word(tick_word());
        w = '{mpcs_pkg::OP_LOAD, 3'd0, 13'd1, 16'd0, 8'd0, 1'b1, 8'd0, 8'd0, 8'd0};
        send_word(w);
        w = '{mpcs_pkg::OP_LOAD, 3'd7, 13'h1fff, 16'd1, 8'd3, 1'b1, 8'd0, 8'd0, 8'hff};
        send_word(w);
        w = '{mpcs_pkg::OP_LOAD, 3'd3, 13'd77, 16'd1, 8'd2, 1'b1, 8'd1, 8'd2, 8'd0};
        send_word(w);
        w = '{mpcs_pkg::OP_LOAD, 3'd5, 13'd55, 16'hffff, 8'hff, 1'b0, 8'hfe, 8'hff, 8'd9};
        send_word(w);
        repeat (14) send_word(tick_word());

        for (int ph = 0; ph < 4; ph++)
        begin
            sender_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 74 : 34) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 74 : 34) : 0;
            for (int p = 0; p < 8; p++)
            begin
                write_reg(mpcs_pkg::CFG_POLICY,
                    (p < 6) ? p[7:0] : {5'd0, 3'($urandom_range(7, 6))});
                if (p == 5)
                    write_reg(mpcs_pkg::CFG_QUANTUM, ph[0] ? 8'd255 : ((ph == 2) ? 8'd0 :
                        8'($urandom_range(4, 1))));
                run_program($urandom_range(8, 1), $urandom_range(18, 4));
            end
            sender_idle_pct = 0;
            recv_stall_pct = 0;
        end
        write_reg(mpcs_pkg::CFG_QUANTUM, 8'd1);
        write_reg(mpcs_pkg::CFG_POLICY, {5'd0, mpcs_pkg::POL_RR});
        run_program(3, 12);

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        $display("sent %0d words over all six policies and four idle/stall mixes,",
            words_sent);
        $display("checked %0d results including %0d process completions",
            sb.results, sb.completions);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
